// ===== src/ccso_pkg.sv =====
// Package for the clocked command shift-out block.
// Holds the transaction payload types, field widths and shared constants.
// No dependencies.
package ccso_pkg;

	localparam int CMD_W      = 16;
	localparam int LEN_W      = 5;
	localparam int TICK_W     = 24;
	localparam int MAX_BITS   = 16;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(50000);

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	typedef struct packed {
		logic              op;
		logic              clock_level;
		logic [CMD_W-1:0]  command_bits;
		logic [LEN_W-1:0]  command_length;
		logic [TICK_W-1:0] hold_ticks;
	} ccso_in_t;

	typedef struct packed {
		logic line_driven;
		logic line_level;
		logic busy_res;
		logic done_res;
		logic failed;
	} ccso_out_t;

endpackage

// ===== src/clocked_command_shift_out_top.sv =====
// Clocked command shift-out: sequencer, timeout counter and output register.
// Depends on ccso_pkg for payload types and constants.
//
// Usage: each input transaction is one sample of the partner clock line (op = tick) or
// a start command carrying the bits, length and hold time (also counted as a tick).
// Every input transaction yields exactly one output transaction giving the data line
// state (driven, level), busy, and one-transaction done / failed pulses.
// A start while busy is treated as a plain tick.
// Flow: an accepted input transaction is held in the input register, and the result
// register loads from it when the result slot is free. Throughput: one transaction per
// cycle while the receiver does not stall, set by the single pass of the sequencer logic
// between the input register and the result register.
// When the receiver stalls, the result register holds and the input register still
// takes one more transaction; in_ready drops only when both are full.
// The user writes timeout_ticks via cfg_we / cfg_data only while the block is idle; the block does not enforce it.
// Reset (arst_n low) returns the sequencer to idle, empties both registers and sets
// timeout_ticks to 50000.
module clocked_command_shift_out_top
	import ccso_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ccso_in_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ccso_out_t         out_data,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_data
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PRE  = 2'd1;
	localparam logic [1:0] PH_POST = 2'd2;
	localparam logic [1:0] PH_HOLD = 2'd3;

	logic              valid_s1;
	ccso_in_t          item_s1;
	logic              out_valid_q;
	ccso_out_t         out_q;
	logic              advance;

	logic [TICK_W-1:0] timeout_q;
	logic [1:0]        phase_q, phase_d;
	logic [CMD_W-1:0]  shift_q, shift_d;
	logic [LEN_W-1:0]  bits_left_q, bits_left_d;
	logic              last_clock_q, last_clock_d;
	logic [TICK_W-1:0] wait_q, wait_d;
	logic [TICK_W-1:0] hold_q, hold_d;
	logic              data_out_q, data_out_d;
	logic              done_d, fail_d;
	logic [LEN_W-1:0]  len_sat;
	ccso_out_t         res_d;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Saturate the command length to the shift word size.
	assign len_sat = (32'(item_s1.command_length) > MAX_BITS) ? LEN_W'(MAX_BITS)
		: item_s1.command_length;

	always_comb begin
		phase_d      = phase_q;
		shift_d      = shift_q;
		bits_left_d  = bits_left_q;
		last_clock_d = last_clock_q;
		wait_d       = wait_q;
		hold_d       = hold_q;
		data_out_d   = data_out_q;
		done_d       = 1'b0;
		fail_d       = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (item_s1.op == OP_START) begin
					shift_d      = item_s1.command_bits;
					bits_left_d  = len_sat;
					last_clock_d = item_s1.clock_level;
					wait_d       = '0;
					data_out_d   = 1'b0;
					hold_d       = item_s1.hold_ticks;
					if (len_sat == '0) begin
						data_out_d = 1'b1;
						if (item_s1.hold_ticks == '0) begin
							done_d = 1'b1;
						end else begin
							phase_d = PH_HOLD;
						end
					end else begin
						phase_d = PH_PRE;
					end
				end
			end
			PH_PRE, PH_POST: begin
				if (item_s1.clock_level != last_clock_q) begin
					last_clock_d = item_s1.clock_level;
					wait_d       = '0;
					if (phase_q == PH_PRE) begin
						data_out_d = shift_q[0];
						shift_d    = shift_q >> 1;
						if (bits_left_q != '0) begin
							bits_left_d = bits_left_q - LEN_W'(1);
						end
						phase_d = PH_POST;
					end else if (bits_left_q == '0) begin
						// last bit out: release the line and start the hold, or finish if there is none
						data_out_d = 1'b1;
						if (hold_q == '0) begin
							phase_d = PH_IDLE;
							done_d  = 1'b1;
						end else begin
							phase_d = PH_HOLD;
						end
					end else begin
						phase_d = PH_PRE;
					end
				end else if (wait_q >= timeout_q) begin
					data_out_d = 1'b1;
					wait_d     = '0;
					phase_d    = PH_IDLE;
					fail_d     = 1'b1;
				end else begin
					wait_d = wait_q + TICK_W'(1);
				end
			end
			PH_HOLD: begin
				hold_d = (hold_q != '0) ? hold_q - TICK_W'(1) : hold_q;
				if (hold_d == '0) begin
					phase_d = PH_IDLE;
					done_d  = 1'b1;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		res_d.line_driven = (phase_d == PH_PRE) || (phase_d == PH_POST);
		res_d.line_level  = res_d.line_driven && data_out_d;
		res_d.busy_res    = (phase_d != PH_IDLE);
		res_d.done_res    = done_d;
		res_d.failed      = fail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			timeout_q    <= TIMEOUT_RESET;
			phase_q      <= PH_IDLE;
			shift_q      <= '0;
			bits_left_q  <= '0;
			last_clock_q <= 1'b0;
			wait_q       <= '0;
			hold_q       <= '0;
			data_out_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q  <= 1'b1;
				phase_q      <= phase_d;
				shift_q      <= shift_d;
				bits_left_q  <= bits_left_d;
				last_clock_q <= last_clock_d;
				wait_q       <= wait_d;
				hold_q       <= hold_d;
				data_out_q   <= data_out_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (advance) begin
			out_q <= res_d;
		end
	end

endmodule

// ===== src/ccso_chk.sv =====
// Port-level checker for clocked_command_shift_out_top, attached by bind.
// Depends on ccso_pkg for the payload types.
module ccso_chk
	import ccso_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input ccso_out_t         out_data
);

	// A completed or aborted transaction leaves the block idle.
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.done_res || out_data.failed) |-> !out_data.busy_res)
		else $error("done or failed reported while still busy");

	a_one_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.done_res && out_data.failed))
		else $error("done and failed in the same transaction");

	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.line_driven |-> out_data.busy_res)
		else $error("line driven while not busy");

	a_level_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.line_level |-> out_data.line_driven)
		else $error("line level high on a released line");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled output transaction changed");

endmodule

bind clocked_command_shift_out_top ccso_chk u_ccso_chk (.*);
